// File: rtl/assert_macros.svh
// Shared assertion forms for the congestion window block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCPR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcpr: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCPR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcpr: next-cycle check failed");

`endif

// File: rtl/tcpr_pkg.sv
`timescale 1ns / 1ps

package tcpr_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  localparam logic [1:0] KIND_NEW     = 2'd0;
  localparam logic [1:0] KIND_STALE   = 2'd1;
  localparam logic [1:0] KIND_DUP     = 2'd2;
  localparam logic [1:0] KIND_TIMEOUT = 2'd3;

  localparam logic [1:0] PH_SLOW_START = 2'd0;
  localparam logic [1:0] PH_AVOID      = 2'd1;
  localparam logic [1:0] PH_RECOVERY   = 2'd2;

  localparam logic [1:0] REG_INIT_THR  = 2'd0;
  localparam logic [1:0] REG_INIT_WIN  = 2'd1;
  localparam logic [1:0] REG_DUP_LIMIT = 2'd2;

  localparam logic [15:0] RESET_THRESHOLD = 16'd64;
  localparam logic [15:0] RESET_WINDOW    = 16'd1;
  localparam logic [3:0]  RESET_DUP_LIMIT = 4'd3;
  localparam logic [3:0]  DUP_MAX         = 4'd15;
  localparam logic [16:0] RECOVERY_BUMP   = 17'd3;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    sat32 = (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

endpackage

// File: rtl/tcpr_div.sv
`timescale 1ns / 1ps

module tcpr_div #(
  parameter int QW = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [31:0]   divisor,
  output logic          done,
  output logic [QW-1:0] quotient
);

  localparam int CW = $clog2(QW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [31:0]   rem;
  logic [31:0]   dsr;
  logic [QW-1:0] quo;
  logic [32:0]   trial;
  logic [32:0]   diff;
  logic          ge;

  // The dividend is a single one at bit QW-1, so only the first step shifts in a one.
  assign trial = {rem, (cnt == CW'(QW))};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[31:0] : trial[31:0];
      quo <= {quo[QW-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

// File: rtl/tcp_reno_congestion_window.sv
// Channel  | Direction | Beat contents
// item     | in        | cmd, ack_number
// result   | out       | window_q16, threshold, phase, ack_kind, window_base
// apb      | in/out    | register writes and reads, byte address 4*index
//
// A timeout, slow start ack, duplicate or stale ack passes from accept through
// ST_DECIDE to ST_EMIT. A congestion avoidance ack also waits in ST_DIVIDE for
// the bit-serial restoring divider that forms the 1/window increment.
// The block takes one item at a time; item_stall is high from accept until the
// result is loaded into the output register, which may still hold the previous beat.
// Reset is synchronous and loads the register defaults into the window state.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcp_reno_congestion_window #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        cmd,
  input  logic [30:0] ack_number,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] window_q16,
  output logic [15:0] threshold,
  output logic [1:0]  phase,
  output logic [1:0]  ack_kind,
  output logic [30:0] window_base,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int QW = 2 * FRAC_BITS + 1;
  localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;

  tcpr_pkg::state_t state, state_next;

  logic [15:0] init_thr;
  logic [15:0] init_win;
  logic [3:0]  dup_limit;

  logic [31:0] window;
  logic [15:0] ss_thr;
  logic [30:0] base_seq;
  logic [3:0]  dup_count;
  logic [1:0]  phase_reg;
  logic [1:0]  kind_r;
  logic        cmd_r;
  logic [30:0] ack_r;

  logic          cfg_write;
  logic          div_start;
  logic          div_done;
  logic [QW-1:0] div_quo;
  logic          load_out;
  logic          out_free;

  logic [31:0] half_raw;
  logic [15:0] half;
  logic        in_slow_start;
  logic        is_new;
  logic        is_stale;
  logic [3:0]  dup_inc;
  logic [31:0] win_plus_one;
  logic [31:0] win_recover;
  logic [31:0] win_div;
  logic [31:0] cfg_win;
  logic [31:0] divisor;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_comb begin
    case (paddr[3:2])
      tcpr_pkg::REG_INIT_THR:  prdata = {16'd0, init_thr};
      tcpr_pkg::REG_INIT_WIN:  prdata = {16'd0, init_win};
      tcpr_pkg::REG_DUP_LIMIT: prdata = {28'd0, dup_limit};
      default:                 prdata = 32'd0;
    endcase
  end

  assign half_raw      = window >> (FRAC_BITS + 1);
  assign half          = (|half_raw[31:16]) ? 16'hFFFF : half_raw[15:0];
  assign in_slow_start = {32'd0, window} < ({48'd0, ss_thr} << FRAC_BITS);
  assign is_new        = ack_r >= base_seq;
  assign is_stale      = ack_r < (base_seq - 31'd1);
  assign dup_inc       = (dup_count == tcpr_pkg::DUP_MAX) ? dup_count : dup_count + 4'd1;
  assign win_plus_one  = tcpr_pkg::sat32({32'd0, window} + ONE_Q);
  assign win_recover   = tcpr_pkg::sat32(
                           {47'd0, {1'b0, half} + tcpr_pkg::RECOVERY_BUMP} << FRAC_BITS);
  assign win_div       = tcpr_pkg::sat32({32'd0, window} + {{(64-QW){1'b0}}, div_quo});
  assign cfg_win       = tcpr_pkg::sat32({48'd0, pwdata[15:0]} << FRAC_BITS);
  assign divisor       = (window == 32'd0) ? 32'd1 : window;
  assign out_free      = !result_valid || !result_stall;

  tcpr_div #(
    .QW(QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_next = state;
    case (state)
      tcpr_pkg::ST_IDLE:   if (item_valid) state_next = tcpr_pkg::ST_DECIDE;
      tcpr_pkg::ST_DECIDE: begin
        if (!cmd_r && is_new && !in_slow_start) begin
          state_next = tcpr_pkg::ST_DIVIDE;
        end else begin
          state_next = tcpr_pkg::ST_EMIT;
        end
      end
      tcpr_pkg::ST_DIVIDE: if (div_done) state_next = tcpr_pkg::ST_EMIT;
      tcpr_pkg::ST_EMIT:   if (out_free) state_next = tcpr_pkg::ST_IDLE;
      default:             state_next = tcpr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall = 1'b1;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      tcpr_pkg::ST_IDLE:   item_stall = 1'b0;
      tcpr_pkg::ST_DECIDE: div_start  = !cmd_r && is_new && !in_slow_start;
      tcpr_pkg::ST_DIVIDE: item_stall = 1'b1;
      tcpr_pkg::ST_EMIT:   load_out   = out_free;
      default:             item_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcpr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_thr  <= tcpr_pkg::RESET_THRESHOLD;
      init_win  <= tcpr_pkg::RESET_WINDOW;
      dup_limit <= tcpr_pkg::RESET_DUP_LIMIT;
      ss_thr    <= tcpr_pkg::RESET_THRESHOLD;
      window    <= tcpr_pkg::sat32({48'd0, tcpr_pkg::RESET_WINDOW} << FRAC_BITS);
      base_seq  <= '0;
      dup_count <= '0;
      phase_reg <= tcpr_pkg::PH_SLOW_START;
    end else begin
      if (cfg_write) begin
        case (paddr[3:2])
          tcpr_pkg::REG_INIT_THR: begin
            init_thr <= pwdata[15:0];
            ss_thr   <= pwdata[15:0];
          end
          tcpr_pkg::REG_INIT_WIN: begin
            init_win <= pwdata[15:0];
            window   <= cfg_win;
          end
          tcpr_pkg::REG_DUP_LIMIT: dup_limit <= pwdata[3:0];
          default: ;
        endcase
      end
      if (state == tcpr_pkg::ST_DECIDE) begin
        if (cmd_r) begin
          ss_thr    <= half;
          window    <= ONE_Q[31:0];
          dup_count <= '0;
          phase_reg <= tcpr_pkg::PH_SLOW_START;
        end else if (is_new) begin
          if (in_slow_start) begin
            window    <= win_plus_one;
            phase_reg <= tcpr_pkg::PH_SLOW_START;
            dup_count <= '0;
            base_seq  <= ack_r;
          end
        end else if (!is_stale) begin
          dup_count <= dup_inc;
          if (dup_inc == dup_limit) begin
            ss_thr    <= half;
            window    <= win_recover;
            phase_reg <= tcpr_pkg::PH_RECOVERY;
          end else if (dup_inc > dup_limit) begin
            window <= win_plus_one;
          end
        end
      end
      if (state == tcpr_pkg::ST_DIVIDE && div_done) begin
        window    <= win_div;
        phase_reg <= tcpr_pkg::PH_AVOID;
        dup_count <= '0;
        base_seq  <= ack_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == tcpr_pkg::ST_IDLE && item_valid) begin
      cmd_r <= cmd;
      ack_r <= ack_number;
    end
    if (state == tcpr_pkg::ST_DECIDE) begin
      if (cmd_r) begin
        kind_r <= tcpr_pkg::KIND_TIMEOUT;
      end else if (is_new) begin
        kind_r <= tcpr_pkg::KIND_NEW;
      end else if (is_stale) begin
        kind_r <= tcpr_pkg::KIND_STALE;
      end else begin
        kind_r <= tcpr_pkg::KIND_DUP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      window_q16  <= window;
      threshold   <= ss_thr;
      phase       <= phase_reg;
      ack_kind    <= kind_r;
      window_base <= base_seq;
    end
  end

  // The divider only finishes while the sequencer waits for it.
  `TCPR_ASSERT_IMP(a_div_done_in_divide, clk, rst, div_done, state == tcpr_pkg::ST_DIVIDE)
  // A timeout leaves exactly one packet in the window.
  `TCPR_ASSERT_NXT(a_timeout_window, clk, rst, state == tcpr_pkg::ST_DECIDE && cmd_r,
                   window == ONE_Q[31:0])
  // A finished result is always presented in the following cycle.
  `TCPR_ASSERT_NXT(a_emit_presents, clk, rst, load_out, result_valid)

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int FRAC = 16;
  localparam int DRAIN_CYCLES = 2 * FRAC + 16;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 140;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam logic [63:0] ONE_PKT = 64'd1 << FRAC;
  localparam logic [30:0] SEQ_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [31:0] window_q16;
    logic [15:0] threshold;
    logic [1:0]  phase;
    logic [1:0]  ack_kind;
    logic [30:0] window_base;
  } reno_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        cmd = 1'b0;
  logic [30:0] ack_number = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [31:0] window_q16;
  logic [15:0] threshold;
  logic [1:0]  phase;
  logic [1:0]  ack_kind;
  logic [30:0] window_base;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor copy of the congestion state and its registers.
  logic [15:0] cfg_init_thr = tcpr_pkg::RESET_THRESHOLD;
  logic [15:0] cfg_init_win = tcpr_pkg::RESET_WINDOW;
  logic [3:0]  cfg_dup_limit = tcpr_pkg::RESET_DUP_LIMIT;
  logic [31:0] cwnd = 32'(tcpr_pkg::RESET_WINDOW) << FRAC;
  logic [15:0] ssthresh = tcpr_pkg::RESET_THRESHOLD;
  logic [30:0] ack_base = '0;
  logic [3:0]  dup_run = '0;
  logic [1:0]  cc_phase = tcpr_pkg::PH_SLOW_START;

  reno_beat_t predicted_beats[$];
  reno_beat_t want_beat;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit idle_on = 1'b1;
  bit stall_on = 1'b1;
  logic holding = 1'b0;
  event hold_ev;

  tcp_reno_congestion_window #(.FRAC_BITS(FRAC)) uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .cmd(cmd),
    .ack_number(ack_number),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .window_q16(window_q16),
    .threshold(threshold),
    .phase(phase),
    .ack_kind(ack_kind),
    .window_base(window_base),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] clamp_window(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [15:0] halve_window(input logic [31:0] w);
    logic [31:0] h;
    h = w >> (FRAC + 1);
    return (h > 32'hFFFF) ? 16'hFFFF : h[15:0];
  endfunction

  function automatic reno_beat_t reno_predict(input logic c, input logic [30:0] ack);
    reno_beat_t r;
    logic [63:0] divisor;
    if (c) begin
      ssthresh = halve_window(cwnd);
      cwnd = ONE_PKT[31:0];
      dup_run = '0;
      cc_phase = tcpr_pkg::PH_SLOW_START;
      r.ack_kind = tcpr_pkg::KIND_TIMEOUT;
    end else if (ack >= ack_base) begin
      dup_run = '0;
      if ({32'd0, cwnd} < ({48'd0, ssthresh} << FRAC)) begin
        cwnd = clamp_window({32'd0, cwnd} + ONE_PKT);
        cc_phase = tcpr_pkg::PH_SLOW_START;
      end else begin
        // A zero window divides by one, which drives the window to its ceiling.
        divisor = (cwnd == 32'd0) ? 64'd1 : {32'd0, cwnd};
        cwnd = clamp_window({32'd0, cwnd} + ((64'd1 << (2 * FRAC)) / divisor));
        cc_phase = tcpr_pkg::PH_AVOID;
      end
      ack_base = ack;
      r.ack_kind = tcpr_pkg::KIND_NEW;
    end else if ({1'b0, ack} < {1'b0, ack_base} - 32'd1) begin
      r.ack_kind = tcpr_pkg::KIND_STALE;
    end else begin
      if (dup_run < tcpr_pkg::DUP_MAX) dup_run++;
      if (dup_run == cfg_dup_limit) begin
        ssthresh = halve_window(cwnd);
        cwnd = clamp_window(({48'd0, ssthresh} + 64'(tcpr_pkg::RECOVERY_BUMP)) << FRAC);
        cc_phase = tcpr_pkg::PH_RECOVERY;
      end else if (dup_run > cfg_dup_limit) begin
        cwnd = clamp_window({32'd0, cwnd} + ONE_PKT);
      end
      r.ack_kind = tcpr_pkg::KIND_DUP;
    end
    r.window_q16 = cwnd;
    r.threshold = ssthresh;
    r.phase = cc_phase;
    r.window_base = ack_base;
    return r;
  endfunction

  function automatic logic [30:0] ack_ahead(input int unsigned step);
    logic [31:0] sum;
    sum = {1'b0, ack_base} + step;
    return sum[31] ? SEQ_MAX : sum[30:0];
  endfunction

  task automatic send_item(input logic c, input logic [30:0] ack);
    cmd <= c;
    ack_number <= ack;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall !== 1'b0);
    predicted_beats.push_back(reno_predict(c, ack));
    while (idle_on && $urandom_range(99) < 38) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (predicted_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      tcpr_pkg::REG_INIT_THR: begin
        cfg_init_thr = value[15:0];
        ssthresh = value[15:0];
      end
      tcpr_pkg::REG_INIT_WIN: begin
        cfg_init_win = value[15:0];
        cwnd = clamp_window({48'd0, value[15:0]} << FRAC);
      end
      tcpr_pkg::REG_DUP_LIMIT: cfg_dup_limit = value[3:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [31:0] thr, input logic [31:0] win,
                                input logic [31:0] lim);
    wait_drained();
    write_reg(tcpr_pkg::REG_INIT_THR, thr);
    write_reg(tcpr_pkg::REG_INIT_WIN, win);
    write_reg(tcpr_pkg::REG_DUP_LIMIT, lim);
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      fail_count++;
    end
  endtask

  task automatic test_directed_acks();
    // With the base at zero every ack counts as new, including a repeat of zero.
    send_item(1'b0, 31'd0);
    send_item(1'b0, 31'd0);
    send_item(1'b0, 31'd10);
    send_item(1'b0, 31'd20);
    send_item(1'b0, 31'd30);
    repeat (5) send_item(1'b0, 31'd29);
    send_item(1'b0, 31'd5);
    send_item(1'b0, 31'd0);
    send_item(1'b0, 31'd40);
    send_item(1'b0, 31'd40);
    send_item(1'b1, SEQ_MAX);
    send_item(1'b1, 31'd0);
    send_item(1'b0, 31'd41);
  endtask

  task automatic test_register_extremes();
    apply_settings(32'd0, 32'd0, 32'd1);
    send_item(1'b0, ack_ahead(5));
    send_item(1'b0, ack_ahead(5));
    repeat (2) send_item(1'b0, ack_base - 31'd1);
    send_item(1'b1, 31'h5555_5555);
    apply_settings(32'hFFFF, 32'hFFFF, 32'd0);
    send_item(1'b0, ack_ahead(1));
    repeat (3) send_item(1'b0, ack_base - 31'd1);
    send_item(1'b1, 31'h2AAA_AAAA);
    apply_settings(32'd64, 32'd1, 32'd15);
    repeat (17) send_item(1'b0, ack_base - 31'd1);
    wait_drained();
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    send_item(1'b0, ack_ahead(2));
    send_item(1'b0, ack_base - 31'd1);
    apply_settings(32'(tcpr_pkg::RESET_THRESHOLD), 32'(tcpr_pkg::RESET_WINDOW),
                   32'(tcpr_pkg::RESET_DUP_LIMIT));
  endtask

  task automatic test_output_hold();
    wait_drained();
    -> hold_ev;
    repeat (20) send_item(1'b0, ack_ahead($urandom_range(1, 50)));
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned pick;
    int unsigned run;
    logic [15:0] thr;
    logic [15:0] win;
    logic [3:0]  lim;
    logic [30:0] lo;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      pick = $urandom_range(5);
      thr = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(1, 120));
      pick = $urandom_range(7);
      win = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(1, 100));
      lim = $urandom_range(1) ? 4'($urandom_range(1, 4)) : 4'($urandom_range(15));
      apply_settings({16'($urandom), thr}, {16'($urandom), win}, {28'($urandom), lim});
      // One phase runs with both sides at full rate.
      idle_on = (p != 1);
      stall_on = (p != 1);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          run = $urandom_range(1, 8);
          repeat (run) send_item(1'b0, ack_ahead($urandom_range(3000)));
          sent += run;
        end else if (pick < 70 && ack_base != 0) begin
          run = $urandom_range(1, 18);
          repeat (run) send_item(1'b0, ack_base - 31'd1);
          sent += run;
        end else if (pick < 80 && ack_base > 1) begin
          send_item(1'b0, 31'($urandom_range({1'b0, ack_base} - 32'd2)));
          sent++;
        end else if (pick < 90) begin
          send_item(1'b1, 31'($urandom));
          sent++;
        end else begin
          lo = (ack_base > 31'd200) ? ack_base - 31'd200 : 31'd0;
          if ($urandom_range(199) == 0) begin
            send_item(1'($urandom_range(1)), 31'($urandom));
          end else begin
            send_item(1'($urandom_range(1)), 31'($urandom_range(ack_ahead(200), lo)));
          end
          sent++;
        end
        if ($urandom_range(49) == 0) wait_drained();
      end
    end
    idle_on = 1'b1;
    stall_on = 1'b1;
  endtask

  task automatic test_base_ceiling();
    send_item(1'b0, SEQ_MAX);
    repeat (3) send_item(1'b0, SEQ_MAX - 31'd1);
    send_item(1'b0, SEQ_MAX);
    send_item(1'b0, 31'd0);
    send_item(1'b1, 31'd0);
  endtask

  always @(posedge clk) begin
    result_stall <= holding || (stall_on && $urandom_range(99) < 38);
  end

  initial begin
    forever begin
      @(hold_ev);
      @(posedge clk);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      holding <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall == 1'b0) begin
      if (predicted_beats.size() == 0) begin
        $error("result beat arrived with no prediction pending");
        fail_count++;
      end else begin
        want_beat = predicted_beats.pop_front();
        check_field("window_q16", want_beat.window_q16, window_q16);
        check_field("threshold", want_beat.threshold, threshold);
        check_field("phase", want_beat.phase, phase);
        check_field("ack_kind", want_beat.ack_kind, ack_kind);
        check_field("window_base", want_beat.window_base, window_base);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tcp_reno_congestion_window: mismatch");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_acks();
    test_register_extremes();
    test_output_hold();
    test_random_traffic();
    test_base_ceiling();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tcp_reno_congestion_window: match");
    end else begin
      $display("tcp_reno_congestion_window: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tcpr_pkg.sv
rtl/tcpr_div.sv
rtl/tcp_reno_congestion_window.sv
dv/tb_top.sv
